>>> hw/rtl/hbp_pkg.sv
// Shared types, constants and helper functions for the Huffman bit packer.
// No dependencies; imported by every other file of the block except hbp_ram.
`timescale 1ns / 1ps
package hbp_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CMD_W        = 2;
    localparam int SYM_W        = 8;
    localparam int PAD_W        = 3;
    localparam int BYTES_PER_JOB = 4;
    localparam int JOB_W        = BYTES_PER_JOB * BYTE_BITS;
    localparam int CNT_W        = 3;
    localparam int PEND_W       = BYTE_BITS - 1;
    localparam int MERGE_W      = CODE_W + BYTE_BITS;

    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [JOB_W-1:0] data;
        logic [CNT_W-1:0] cnt;
        logic             byte_valid;
        logic [PAD_W-1:0] pad;
    } t_job;

    function automatic logic [CODE_W-1:0] bit_rev(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        for (int i = 0; i < CODE_W; i++) begin
            r[CODE_W-1-i] = v[i];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/hbp_merge.sv
// Bit merge stage: joins looked-up code bits to the pending bit buffer and
// forms a job of up to four bytes. Depends on hbp_pkg.
`timescale 1ns / 1ps
module hbp_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_flush,
    input  logic [hbp_pkg::CODE_W-1:0]  i_code,
    input  logic [hbp_pkg::LEN_W-1:0]   i_len,
    output hbp_pkg::t_job               o_job
);
    import hbp_pkg::*;

    logic [PEND_W-1:0]  r_pend;
    logic [CNT_W-1:0]   r_pcnt;
    logic [PEND_W-1:0]  n_pend;
    logic [CNT_W-1:0]   n_pcnt;
    logic [CODE_W:0]    w_ones;
    logic [CODE_W-1:0]  w_mask;
    logic [MERGE_W-1:0] w_code_al;
    logic [MERGE_W-1:0] w_merged;
    logic [LEN_W-1:0]   w_total;
    logic [CNT_W-1:0]   w_nb;
    logic [PEND_W-1:0]  w_rest;

    assign w_ones    = '1;
    assign w_mask    = CODE_W'(~(w_ones << i_len));
    assign w_code_al = {bit_rev(i_code & w_mask), {BYTE_BITS{1'b0}}};
    assign w_merged  = {r_pend, {(MERGE_W-PEND_W){1'b0}}} | (w_code_al >> r_pcnt);
    assign w_total   = LEN_W'(r_pcnt) + i_len;
    assign w_nb      = w_total[LEN_W-1:3];

    always_comb begin
        case (w_nb)
            3'd0:    w_rest = w_merged[MERGE_W-1 -: PEND_W];
            3'd1:    w_rest = w_merged[MERGE_W-1-BYTE_BITS -: PEND_W];
            3'd2:    w_rest = w_merged[MERGE_W-1-2*BYTE_BITS -: PEND_W];
            3'd3:    w_rest = w_merged[MERGE_W-1-3*BYTE_BITS -: PEND_W];
            default: w_rest = w_merged[MERGE_W-1-4*BYTE_BITS -: PEND_W];
        endcase
    end

    always_comb begin
        if (i_flush) begin
            o_job.data       = {r_pend, 1'b0, {(JOB_W-BYTE_BITS){1'b0}}};
            o_job.cnt        = CNT_W'(1);
            o_job.byte_valid = (r_pcnt != '0);
            o_job.pad        = (r_pcnt != '0) ? PAD_W'(BYTE_BITS - int'(r_pcnt)) : '0;
            n_pend           = '0;
            n_pcnt           = '0;
        end else begin
            o_job.data       = w_merged[MERGE_W-1 -: JOB_W];
            o_job.cnt        = w_nb;
            o_job.byte_valid = 1'b1;
            o_job.pad        = '0;
            n_pend           = w_rest;
            n_pcnt           = w_total[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_advance) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end
endmodule

>>> hw/rtl/hbp_emit.sv
// Output serializer: holds one job and sends its bytes one beat at a time.
// Depends on hbp_pkg.
`timescale 1ns / 1ps
module hbp_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  hbp_pkg::t_job               i_job,
    output logic                        o_ready,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [hbp_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);
    import hbp_pkg::*;

    logic             r_valid;
    logic [JOB_W-1:0] r_data;
    logic [CNT_W-1:0] r_left;
    logic             r_bvalid;
    logic [PAD_W-1:0] r_pad;
    logic             w_beat;
    logic             w_done;

    assign w_beat  = r_valid && i_m_tready;
    assign w_done  = w_beat && (r_left == CNT_W'(1));
    assign o_ready = !r_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left  <= i_job.cnt;
        end else if (w_beat) begin
            r_valid <= !w_done;
            r_left  <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data   <= i_job.data;
            r_bvalid <= i_job.byte_valid;
            r_pad    <= i_job.pad;
        end else if (w_beat) begin
            r_data   <= {r_data[JOB_W-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(M_TDATA_W-PAD_W-BYTE_BITS){1'b0}}, r_pad,
                         r_data[JOB_W-1 -: BYTE_BITS]};
    assign o_m_tuser  = r_bvalid;
    assign o_m_tlast  = (r_left == CNT_W'(1));
endmodule

>>> hw/rtl/huffman_bit_packer.sv
// Huffman bit packer top level: code store RAM, bit merge stage, output serializer.
// Depends on hbp_pkg, hbp_ram, hbp_merge and hbp_emit.
`timescale 1ns / 1ps
// Usage:
//   Input stream (s side): tuser[1:0] is the command (load, encode, flush);
//   tdata carries symbol, code word and code length. A load writes the code
//   store in the beat's cycle and gives no output. An encode reads the store,
//   merges the registered code bits (bit 0 first) into the pending buffer
//   and yields zero to four bytes. A flush yields exactly one beat: the last
//   bits zero-padded, or a beat with tuser low when nothing was pending.
//   Output stream (m side): one byte per beat, earliest bit in bit 7, pad
//   count in tdata[10:8], tlast on the final beat caused by one input beat.
//   First output beat: after the store read register and the serializer register.
//   Throughput: one input beat per cycle while each item yields at most one
//   byte and the receiver does not stall; an item that yields more bytes
//   occupies the single-byte output port for one beat per byte. The output
//   serializer takes the next job in the cycle its last beat leaves.
//   Reset clears the pending buffer and all handshake state; code store
//   entries hold garbage until loaded. When the receiver stalls, the output
//   beat holds and input ready drops once the merge stage is full.
module huffman_bit_packer #(
    parameter int SYMBOLS      = hbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] symbol, [39:8] code_word, [45:40] code_len, [47:46] zero
    input  logic [hbp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] cmd
    input  logic [hbp_pkg::CMD_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_byte, [10:8] pad_bits, [15:11] zero
    output logic [hbp_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] byte_valid
    output logic                          o_m_tuser,
    output logic                          o_m_tlast
);
    import hbp_pkg::*;

    localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int ENT_W  = CODE_W + LEN_W;

    logic [SYM_W-1:0]  w_sym;
    logic [CODE_W-1:0] w_word;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_len_sat;
    logic              w_sym_ok;
    logic              w_accept;
    logic              w_load;
    logic              w_encode;
    logic              w_flush;
    logic [ENT_W-1:0]  w_rdata;
    logic              r_s1_valid;
    logic              r_s1_flush;
    logic              w_s1_fire;
    logic              w_emit_ready;
    t_job              w_job;

    assign w_sym    = i_s_tdata[SYM_W-1:0];
    assign w_word   = i_s_tdata[SYM_W +: CODE_W];
    assign w_len    = i_s_tdata[SYM_W+CODE_W +: LEN_W];
    assign w_sym_ok = ({1'b0, w_sym} < (SYM_W+1)'(SYMBOLS));
    assign w_len_sat = (w_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : w_len;

    assign w_s1_fire  = r_s1_valid && ((w_job.cnt == '0) || w_emit_ready);
    assign o_s_tready = !r_s1_valid || w_s1_fire;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_accept && (i_s_tuser == CMD_LOAD) && w_sym_ok;
    assign w_encode   = w_accept && (i_s_tuser == CMD_ENCODE) && w_sym_ok;
    assign w_flush    = w_accept && (i_s_tuser == CMD_FLUSH);

    hbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_sym[ADDR_W-1:0]),
        .i_wdata ({w_len_sat, w_word}),
        .i_re    (w_encode),
        .i_raddr (w_sym[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= w_encode || w_flush;
            r_s1_flush <= w_flush;
        end
    end

    hbp_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_s1_fire),
        .i_flush   (r_s1_flush),
        .i_code    (w_rdata[CODE_W-1:0]),
        .i_len     (w_rdata[CODE_W +: LEN_W]),
        .o_job     (w_job)
    );

    hbp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_s1_fire && (w_job.cnt != '0)),
        .i_job      (w_job),
        .o_ready    (w_emit_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );
endmodule

>>> hw/rtl/hbp_checker.sv
// Port-level checks for the Huffman bit packer, bound to the top level.
// Depends on hbp_pkg and huffman_bit_packer.
`timescale 1ns / 1ps
module hbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [hbp_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic [hbp_pkg::CMD_W-1:0]     i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [hbp_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          o_m_tlast
);
    import hbp_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata)
            && $stable(i_s_tuser))
        else $error("stalled input beat changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output beat changed");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata == '0))
        else $error("empty flush beat malformed");

    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[BYTE_BITS +: PAD_W] != '0) |-> o_m_tlast && o_m_tuser)
        else $error("padded byte not final");
endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

>>> tb/sv/huffman_bit_packer_test.sv
// Self-checking testbench for huffman_bit_packer: directed stimulus table, then random
// load/encode/flush traffic, checked beat by beat against a local bit-packing predictor.
// Depends on hbp_pkg and the huffman_bit_packer RTL.
`timescale 1ns / 1ps
module huffman_bit_packer_test;
    import hbp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 134;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED = 22;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       byte_valid;
        logic [2:0] pad;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              typed;
        logic [7:0]        want_byte;
        logic              want_valid;
        logic [2:0]        want_pad;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [CMD_W-1:0]     i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;

    t_out_beat         bytes_due [$];
    logic [CODE_W-1:0] code_mem [256];
    logic [LEN_W-1:0]  len_mem [256];
    bit                loaded [256];
    int                loaded_syms [$];
    logic [6:0]        pend_bits;
    int                pend_cnt;

    int error_cnt = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 32;
    int recv_idle_pct = 52;

    t_stim_row directed_rows [N_DIRECTED] = '{
        {CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'hFF, 32'h0000_0001, 6'd1,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'h55, 32'hAAAA_AAAA, 6'd63, 1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'hAA, 32'h5555_5555, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'h01, 32'hFFFF_FFF5, 6'd4,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'h80, 32'h0000_0003, 6'd33, 1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_LOAD,   8'h7F, 32'h0000_007F, 6'd7,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_UNUSED, 8'h00, 32'h0000_0000, 6'd5,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'h80, 1'b1, 3'd7},
        {CMD_ENCODE, 8'hAA, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 8'hFE, 1'b1, 3'd1},
        {CMD_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0},
        {CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 8'h00, 1'b0, 3'd0}
    };

    huffman_bit_packer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic pack_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len,
                             input logic typed, input t_out_beat want);
        t_out_beat beats [4];
        t_out_beat flush_beat;
        logic [7:0] acc;
        int n;
        n = 0;
        acc = {1'b0, pend_bits};
        case (cmd)
            CMD_LOAD: begin
                code_mem[sym] = word;
                len_mem[sym] = (len > 6'd32) ? 6'd32 : len;
                if (!loaded[sym]) begin
                    loaded[sym] = 1'b1;
                    loaded_syms.push_back(int'(sym));
                end
            end
            CMD_ENCODE: begin
                for (int i = 0; i < int'(len_mem[sym]); i++) begin
                    acc = {acc[6:0], code_mem[sym][i]};
                    pend_cnt++;
                    if (pend_cnt == 8) begin
                        beats[n] = '{byte_val: acc, byte_valid: 1'b1, pad: 3'd0, last: 1'b0};
                        n++;
                        pend_cnt = 0;
                        acc = 8'h00;
                    end
                end
                pend_bits = acc[6:0];
                for (int k = 0; k < n; k++) begin
                    if (k == n - 1) beats[k].last = 1'b1;
                    bytes_due.push_back(beats[k]);
                end
            end
            CMD_FLUSH: begin
                if (pend_cnt == 0) begin
                    flush_beat = '{byte_val: 8'h00, byte_valid: 1'b0, pad: 3'd0, last: 1'b1};
                end else begin
                    flush_beat.byte_val = acc << (8 - pend_cnt);
                    flush_beat.byte_valid = 1'b1;
                    flush_beat.pad = 3'(8 - pend_cnt);
                    flush_beat.last = 1'b1;
                end
                bytes_due.push_back(typed ? want : flush_beat);
                pend_bits = 7'd0;
                pend_cnt = 0;
            end
            default: ;
        endcase
    endtask

    // call right after a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len,
                             input logic typed, input t_out_beat want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {2'b00, len, word, sym};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pack_item(cmd, sym, word, len, typed, want);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_bytes
        t_out_beat exp_beat;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (bytes_due.size() == 0) begin
                $error("unexpected output beat: out_byte %h", o_m_tdata[7:0]);
                error_cnt++;
            end else begin
                exp_beat = bytes_due.pop_front();
                if (o_m_tdata[7:0] !== exp_beat.byte_val) begin
                    $error("out_byte: expected %h, got %h", exp_beat.byte_val, o_m_tdata[7:0]);
                    error_cnt++;
                end
                if (o_m_tuser !== exp_beat.byte_valid) begin
                    $error("byte_valid: expected %b, got %b", exp_beat.byte_valid, o_m_tuser);
                    error_cnt++;
                end
                if (o_m_tdata[10:8] !== exp_beat.pad) begin
                    $error("pad_bits: expected %0d, got %0d", exp_beat.pad, o_m_tdata[10:8]);
                    error_cnt++;
                end
                if (o_m_tlast !== exp_beat.last) begin
                    $error("last: expected %b, got %b", exp_beat.last, o_m_tlast);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        t_out_beat         want;
        int                roll;
        int                taken;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        pend_bits = 7'd0;
        pend_cnt = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            want = '{byte_val: directed_rows[r].want_byte, byte_valid: directed_rows[r].want_valid,
                     pad: directed_rows[r].want_pad, last: 1'b1};
            send_beat(directed_rows[r].cmd, directed_rows[r].sym, directed_rows[r].word,
                      directed_rows[r].len, directed_rows[r].typed, want);
        end

        want = '0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                sym = 8'($urandom_range(0, 255));
                word = $urandom;
                len = ($urandom_range(0, 99) < 25) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(1, 12));
                if (roll < 3) begin
                    cmd = CMD_UNUSED;
                end else if (roll < 13) begin
                    cmd = CMD_LOAD;
                end else if (roll < 22) begin
                    cmd = CMD_FLUSH;
                end else begin
                    cmd = CMD_ENCODE;
                    sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
                end
                send_beat(cmd, sym, word, len, 1'b0, want);
                if (cmd != CMD_UNUSED) taken++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> huffman_bit_packer.f
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_ram.sv
hw/rtl/hbp_merge.sv
hw/rtl/hbp_emit.sv
hw/rtl/huffman_bit_packer.sv
hw/rtl/hbp_checker.sv
tb/sv/huffman_bit_packer_test.sv
